FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the frame parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define EFRU_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed: %m");

// Condition that must never be seen outside reset.
`define EFRU_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen: %m");

`endif

FILE: hw/rtl/efru_pkg.sv
`timescale 1ns / 1ps

package efru_pkg;

  // Frame framing bytes.
  localparam logic [7:0] SYNC_FIRST  = 8'h00;
  localparam logic [7:0] SYNC_SECOND = 8'hAA;

  // Opcodes; status and call frames change link or call state.
  localparam logic [7:0] OP_NONE   = 8'h00;
  localparam logic [7:0] OP_STATUS = 8'h01;
  localparam logic [7:0] OP_CALL   = 8'h02;

  // Status parameter codes.
  localparam logic [7:0] STATUS_LINK_UP   = 8'h05;
  localparam logic [7:0] STATUS_LINK_DOWN = 8'h07;

  // Highest valid call status.
  localparam logic [7:0] CALL_STATUS_MAX = 8'h04;

  localparam int unsigned RESULT_TDATA_W = 16;

  // One result item.
  typedef struct packed {
    logic       frame_done;
    logic       frame_good;
    logic       checksum_error;
    logic [7:0] ack_event_id;
    logic       link_up;
    logic [2:0] call_state;
  } result_t;

endpackage

FILE: hw/rtl/efru_parser.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module efru_parser (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  logic [7:0]              rx_byte_i,
  output efru_pkg::result_t       result_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SYNC,
    PH_LEN_H,
    PH_LEN_L,
    PH_OPCODE,
    PH_PARAM,
    PH_CHECK
  } phase_e;

  // Byte positions within a frame, counted from the first sync byte.
  localparam logic [16:0] POS_SYNC        = 17'd1;
  localparam logic [16:0] POS_LEN_H       = 17'd2;
  localparam logic [16:0] POS_LEN_L       = 17'd3;
  localparam logic [16:0] POS_OPCODE      = 17'd4;
  localparam logic [16:0] POS_FIRST_PARAM = 17'd5;
  localparam logic [16:0] POS_SECOND_PRM  = 17'd6;
  localparam logic [16:0] POS_HEADER      = 17'd3;

  phase_e      phase_q, phase_d;
  logic [16:0] pos_q, pos_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  opcode_q, opcode_d;
  logic [7:0]  param1_q, param1_d;
  logic [7:0]  param2_q, param2_d;
  logic        link_q, link_d;
  logic [2:0]  call_q, call_d;
  logic        done, good, bad;
  logic [7:0]  check_sum;

  assign check_sum = sum_q + rx_byte_i;

  // Per-byte frame state update.
  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    len_d    = len_q;
    sum_d    = sum_q;
    opcode_d = opcode_q;
    param1_d = param1_q;
    param2_d = param2_q;
    link_d   = link_q;
    call_d   = call_q;
    done     = 1'b0;
    good     = 1'b0;
    bad      = 1'b0;
    unique case (phase_q)
      PH_IDLE: begin
        if (rx_byte_i == efru_pkg::SYNC_FIRST) begin
          phase_d = PH_SYNC;
          pos_d   = POS_SYNC;
        end
      end
      PH_SYNC: begin
        if (rx_byte_i == efru_pkg::SYNC_SECOND) begin
          phase_d = PH_LEN_H;
          pos_d   = POS_LEN_H;
        end else begin
          phase_d = PH_IDLE;
        end
      end
      PH_LEN_H: begin
        len_d   = {rx_byte_i, 8'h00};
        sum_d   = rx_byte_i;
        pos_d   = POS_LEN_L;
        phase_d = PH_LEN_L;
      end
      PH_LEN_L: begin
        len_d   = len_q + {8'h00, rx_byte_i};
        sum_d   = sum_q + rx_byte_i;
        pos_d   = POS_OPCODE;
        phase_d = PH_OPCODE;
      end
      PH_OPCODE: begin
        opcode_d = rx_byte_i;
        sum_d    = sum_q + rx_byte_i;
        pos_d    = POS_FIRST_PARAM;
        phase_d  = (len_q <= 16'd1) ? PH_CHECK : PH_PARAM;
      end
      PH_PARAM: begin
        if (pos_q == POS_FIRST_PARAM) begin
          param1_d = rx_byte_i;
        end else if (pos_q == POS_SECOND_PRM) begin
          param2_d = rx_byte_i;
        end
        if (pos_q == {1'b0, len_q} + POS_HEADER) begin
          phase_d = PH_CHECK;
        end
        sum_d = sum_q + rx_byte_i;
        pos_d = pos_q + 17'd1;
      end
      PH_CHECK: begin
        phase_d = PH_IDLE;
        done    = 1'b1;
        // The sum including a correct checksum byte is zero.
        bad     = (check_sum != 8'h00);
        good    = !bad && (opcode_q != efru_pkg::OP_NONE);
        if (good) begin
          if (opcode_q == efru_pkg::OP_STATUS) begin
            if (param1_q == efru_pkg::STATUS_LINK_UP) begin
              link_d = 1'b1;
            end else if (param1_q == efru_pkg::STATUS_LINK_DOWN) begin
              link_d = 1'b0;
            end
          end else if (opcode_q == efru_pkg::OP_CALL) begin
            if (param2_q <= efru_pkg::CALL_STATUS_MAX) begin
              call_d = param2_q[2:0];
            end
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  // Result for the byte being processed.
  always_comb begin
    result_o.frame_done     = done;
    result_o.frame_good     = good;
    result_o.checksum_error = bad;
    result_o.ack_event_id   = done ? opcode_q : 8'h00;
    result_o.link_up        = link_d;
    result_o.call_state     = call_d;
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      pos_q    <= '0;
      len_q    <= '0;
      sum_q    <= '0;
      opcode_q <= '0;
      param1_q <= '0;
      param2_q <= '0;
      link_q   <= 1'b0;
      call_q   <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      len_q    <= len_d;
      sum_q    <= sum_d;
      opcode_q <= opcode_d;
      param1_q <= param1_d;
      param2_q <= param2_d;
      link_q   <= link_d;
      call_q   <= call_d;
    end
  end

  // Parameter bytes are only expected for a length of two or more.
  `EFRU_ASSERT(a_param_len, clk_i, rst_ni, (phase_q == PH_PARAM) |-> (len_q >= 16'd2))
  // The position never runs past the checksum byte.
  `EFRU_ASSERT(a_pos_bound, clk_i, rst_ni,
               (phase_q == PH_PARAM) |-> (pos_q <= {1'b0, len_q} + POS_HEADER))
  // The call status stays in its legal range.
  `EFRU_ASSERT_NEVER(a_call_range, clk_i, rst_ni, call_q > efru_pkg::CALL_STATUS_MAX[2:0])
  // Taking the checksum byte returns the parser to idle.
  `EFRU_ASSERT(a_check_done, clk_i, rst_ni,
               (step_i && phase_q == PH_CHECK) |=> (phase_q == PH_IDLE))

endmodule

FILE: hw/rtl/module_event_frame_receiver_unit.sv
`timescale 1ns / 1ps
// Event frame receiver: takes one received serial byte per item and returns one result
// item per byte, flagging completed frames (0x00, 0xAA, length, opcode, parameters,
// checksum), their checksum status and opcode, and the current link flag and call
// status. It sustains one item per clock cycle while results are being taken; each item
// passes an input register and then a result register, and the per-byte frame state
// update lies between those two registers. Both sides may stall freely; the input
// register keeps taking items while a result waits as long as the result register is
// being emptied.
module module_event_frame_receiver_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] frame_done, [1] frame_good, [2] checksum_error, [10:3] ack_event_id,
  // [11] link_up, [14:12] call_state, [15] zero
  output logic [efru_pkg::RESULT_TDATA_W-1:0] m_axis_tdata
);

  logic              in_valid_q;
  logic [7:0]        in_byte_q;
  logic              out_valid_q;
  efru_pkg::result_t out_res_q;
  efru_pkg::result_t res;
  logic              step;

  // A byte moves on when the result register is free or being emptied.
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  efru_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .rx_byte_i (in_byte_q),
    .result_o  (res)
  );

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0,
                          out_res_q.call_state,
                          out_res_q.link_up,
                          out_res_q.ack_event_id,
                          out_res_q.checksum_error,
                          out_res_q.frame_good,
                          out_res_q.frame_done};

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import efru_pkg::*;

  localparam int ITEMS_TOTAL    = 950;
  localparam int CALM_TAIL      = 120;
  localparam int HOLD_CYCLES    = 120;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;

  // Receive phases of the frame parser.
  typedef enum logic [2:0] {
    RX_IDLE, RX_SYNC, RX_LEN_HI, RX_LEN_LO, RX_OPCODE, RX_PARAM, RX_CHECK
  } rx_phase_e;

  // One result item, laid out as on m_axis_tdata (lowest field last).
  typedef struct packed {
    logic       pad;
    logic [2:0] call;
    logic       link;
    logic [7:0] event_id;
    logic       csum_err;
    logic       good;
    logic       done;
  } frame_status_t;

  // One row of the directed byte table.
  typedef struct packed {
    logic [7:0]    rx;
    logic          typed;
    frame_status_t want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [RESULT_TDATA_W-1:0] m_axis_tdata;

  // Frame parser state of the prediction.
  rx_phase_e   rx_phase = RX_IDLE;
  logic [16:0] rx_pos = '0;
  logic [15:0] rx_len = '0;
  logic [7:0]  rx_sum = '0;
  logic [7:0]  rx_op = '0;
  logic [7:0]  rx_p1 = '0;
  logic [7:0]  rx_p2 = '0;
  logic        link_st = 1'b0;
  logic [2:0]  call_st = '0;

  frame_status_t frame_status_q[$];
  int          mismatch_cnt = 0;
  int          result_cnt = 0;
  bit          gaps_on = 1'b1;
  bit          hold_go = 1'b0;
  int          snd_odds = 4;

  module_event_frame_receiver_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic frame_status_t res_of(input bit done, input bit good, input bit err,
                                           input logic [7:0] id, input bit link,
                                           input logic [2:0] call);
    return {1'b0, call, link, id, err, good, done};
  endfunction

  // Directed rows: a byte whose result is worked out by the predictor, or one with a
  // result typed in.
  function automatic dir_row_t lead(input logic [7:0] b);
    return {b, 1'b0, 16'h0000};
  endfunction

  function automatic dir_row_t at(input logic [7:0] b, input frame_status_t want);
    return {b, 1'b1, want};
  endfunction

  // Advances the parser by one received byte and returns the status it reports.
  function automatic frame_status_t predict_rx_byte(input logic [7:0] b);
    frame_status_t r;
    logic [7:0]    check_byte;
    r = '0;
    case (rx_phase)
      RX_IDLE: begin
        if (b == SYNC_FIRST) begin
          rx_phase = RX_SYNC;
          rx_pos   = 17'd1;
        end
      end
      RX_SYNC: begin
        if (b == SYNC_SECOND) begin
          rx_phase = RX_LEN_HI;
          rx_pos   = 17'd2;
        end else begin
          rx_phase = RX_IDLE;
        end
      end
      RX_LEN_HI: begin
        rx_len   = {b, 8'h00};
        rx_sum   = b;
        rx_pos   = 17'd3;
        rx_phase = RX_LEN_LO;
      end
      RX_LEN_LO: begin
        rx_len   = rx_len + {8'h00, b};
        rx_sum   = rx_sum + b;
        rx_pos   = 17'd4;
        rx_phase = RX_OPCODE;
      end
      RX_OPCODE: begin
        rx_op    = b;
        rx_sum   = rx_sum + b;
        rx_pos   = 17'd5;
        rx_phase = (rx_len <= 16'd1) ? RX_CHECK : RX_PARAM;
      end
      RX_PARAM: begin
        // Only the first two parameters are kept.
        if (rx_pos == 17'd5) begin
          rx_p1 = b;
        end else if (rx_pos == 17'd6) begin
          rx_p2 = b;
        end
        if ({1'b0, rx_pos} == {2'b00, rx_len} + 18'd3) begin
          rx_phase = RX_CHECK;
        end
        rx_sum = rx_sum + b;
        rx_pos = rx_pos + 17'd1;
      end
      RX_CHECK: begin
        check_byte = 8'h00 - rx_sum;
        rx_phase   = RX_IDLE;
        r.done     = 1'b1;
        r.event_id = rx_op;
        r.csum_err = (check_byte != b);
        if (!r.csum_err && rx_op != OP_NONE) begin
          r.good = 1'b1;
          // A good status or call frame acts on the kept parameters.
          if (rx_op == OP_STATUS) begin
            if (rx_p1 == STATUS_LINK_UP) begin
              link_st = 1'b1;
            end else if (rx_p1 == STATUS_LINK_DOWN) begin
              link_st = 1'b0;
            end
          end else if (rx_op == OP_CALL) begin
            if (rx_p2 <= CALL_STATUS_MAX) begin
              call_st = rx_p2[2:0];
            end
          end
        end
      end
      default: begin
        rx_phase = RX_IDLE;
      end
    endcase
    r.link = link_st;
    r.call = call_st;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("ERROR: result %0d, %s: got 0x%0h, expected 0x%0h",
             result_cnt, field, got, want);
    mismatch_cnt++;
  endtask

  // Offers one byte, waits until it is taken and queues its expected status.
  task automatic send_rx_byte(input logic [7:0] b, input logic typed,
                              input frame_status_t want);
    frame_status_t pred;
    if (gaps_on && snd_odds != 0 && $urandom_range(1, snd_odds) == 1) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred = predict_rx_byte(b);
    frame_status_q.push_back(typed ? want : pred);
  endtask

  // Byte source: reset, directed table, then random frames.
  initial begin
    dir_row_t    dir_tab[$];
    logic [7:0]  frame_q[$];
    logic [15:0] flen;
    logic [7:0]  op;
    logic [7:0]  prm;
    logic [7:0]  sum;
    int          sent;
    int          frames;
    int          pick;
    int          cut;
    bit          big_done;
    sent     = 0;
    frames   = 0;
    big_done = 1'b0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Ignored byte after reset, a repeated first sync byte, a bad second sync byte.
    dir_tab.push_back(at(8'h55, res_of(0, 0, 0, OP_NONE, 0, 0)));
    dir_tab.push_back(at(SYNC_FIRST, res_of(0, 0, 0, OP_NONE, 0, 0)));
    dir_tab.push_back(at(SYNC_FIRST, res_of(0, 0, 0, OP_NONE, 0, 0)));
    dir_tab.push_back(at(SYNC_FIRST, res_of(0, 0, 0, OP_NONE, 0, 0)));
    dir_tab.push_back(at(8'h12, res_of(0, 0, 0, OP_NONE, 0, 0)));
    // Status frame that brings the link up.
    dir_tab.push_back(lead(SYNC_FIRST));
    dir_tab.push_back(lead(SYNC_SECOND));
    dir_tab.push_back(lead(8'h00));
    dir_tab.push_back(lead(8'h02));
    dir_tab.push_back(lead(OP_STATUS));
    dir_tab.push_back(lead(STATUS_LINK_UP));
    dir_tab.push_back(at(8'hF8, res_of(1, 1, 0, OP_STATUS, 1, 0)));
    // Call frame of length zero: checksum right after the opcode, old parameter used.
    dir_tab.push_back(lead(SYNC_FIRST));
    dir_tab.push_back(lead(SYNC_SECOND));
    dir_tab.push_back(lead(8'h00));
    dir_tab.push_back(lead(8'h00));
    dir_tab.push_back(lead(OP_CALL));
    dir_tab.push_back(at(8'hFE, res_of(1, 1, 0, OP_CALL, 1, 0)));
    // Zero opcode with a matching checksum is never good.
    dir_tab.push_back(lead(SYNC_FIRST));
    dir_tab.push_back(lead(SYNC_SECOND));
    dir_tab.push_back(lead(8'h00));
    dir_tab.push_back(lead(8'h01));
    dir_tab.push_back(lead(OP_NONE));
    dir_tab.push_back(at(8'hFF, res_of(1, 0, 0, OP_NONE, 1, 0)));
    // Wrong checksum on the largest opcode.
    dir_tab.push_back(lead(SYNC_FIRST));
    dir_tab.push_back(lead(SYNC_SECOND));
    dir_tab.push_back(lead(8'h00));
    dir_tab.push_back(lead(8'h01));
    dir_tab.push_back(lead(8'hFF));
    dir_tab.push_back(at(8'h01, res_of(1, 0, 1, 8'hFF, 1, 0)));

    foreach (dir_tab[i]) begin
      send_rx_byte(dir_tab[i].rx, dir_tab[i].typed, dir_tab[i].want);
      sent++;
    end

    // Random part: mostly well-formed frames, some noise and broken sequences.
    while (sent < ITEMS_TOTAL) begin
      frames++;
      if (sent >= ITEMS_TOTAL - CALM_TAIL) begin
        gaps_on = 1'b0;
      end
      snd_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 12);
      // Keep offering while the result side holds off for a long stretch.
      if (frames == 30) begin
        hold_go = 1'b1;
      end
      if (frames >= 30 && frames < 36) begin
        snd_odds = 0;
      end
      // Pause the byte stream until every expected result is out.
      if (frames == 60) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        while (frame_status_q.size() != 0) @(posedge clk_i);
      end

      frame_q.delete();
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        // Line noise; while idle the parser ignores all but a first sync byte.
        repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom_range(0, 255)));
      end else if (pick == 1) begin
        // First sync byte followed by anything but the second one.
        op = 8'($urandom_range(0, 255));
        if (op == SYNC_SECOND) begin
          op = SYNC_FIRST;
        end
        frame_q.push_back(SYNC_FIRST);
        frame_q.push_back(op);
      end else begin
        if (!big_done && frames >= 100) begin
          flen     = 16'h0100 | 16'($urandom_range(0, 15));
          big_done = 1'b1;
        end else if ($urandom_range(0, 7) != 0) begin
          flen = 16'($urandom_range(0, 4));
        end else begin
          flen = 16'($urandom_range(5, 24));
        end
        pick = $urandom_range(0, 7);
        if (pick == 0) begin
          op = OP_NONE;
        end else if (pick <= 2) begin
          op = OP_STATUS;
        end else if (pick <= 4) begin
          op = OP_CALL;
        end else begin
          op = 8'($urandom_range(0, 255));
        end
        frame_q.push_back(SYNC_FIRST);
        frame_q.push_back(SYNC_SECOND);
        frame_q.push_back(flen[15:8]);
        frame_q.push_back(flen[7:0]);
        frame_q.push_back(op);
        for (int i = 1; i < int'(flen); i++) begin
          prm = 8'($urandom_range(0, 255));
          if (i == 1 && op == OP_STATUS && $urandom_range(0, 3) != 0) begin
            prm = $urandom_range(0, 1) ? STATUS_LINK_UP : STATUS_LINK_DOWN;
          end
          if (i == 2 && op == OP_CALL && $urandom_range(0, 3) != 0) begin
            prm = 8'($urandom_range(0, 7));
          end
          frame_q.push_back(prm);
        end
        sum = 8'h00;
        for (int i = 2; i < frame_q.size(); i++) begin
          sum = sum + frame_q[i];
        end
        sum = 8'h00 - sum;
        if ($urandom_range(0, 7) == 0) begin
          sum = sum + 8'($urandom_range(1, 255));
        end
        frame_q.push_back(sum);
        // Now and then a frame breaks off early.
        if (flen < 16'h0100 && $urandom_range(0, 15) == 0) begin
          cut = $urandom_range(1, frame_q.size() - 1);
          while (frame_q.size() > cut) void'(frame_q.pop_back());
        end
      end
      foreach (frame_q[i]) begin
        send_rx_byte(frame_q[i], 1'b0, '0);
        sent++;
      end
    end

    s_axis_tvalid <= 1'b0;
    while (frame_status_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && frame_status_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Result sink: checks each item and drives tready with random stall bursts.
  initial begin
    frame_status_t got;
    frame_status_t want;
    int            stall_left;
    int            rcv_odds;
    stall_left = 0;
    rcv_odds   = 6;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        result_cnt++;
        if (frame_status_q.size() == 0) begin
          report_mismatch("unexpected result", got, 16'h0000);
        end else begin
          want = frame_status_q.pop_front();
          if (got.done !== want.done) begin
            report_mismatch("frame_done", 16'(got.done), 16'(want.done));
          end
          if (got.good !== want.good) begin
            report_mismatch("frame_good", 16'(got.good), 16'(want.good));
          end
          if (got.csum_err !== want.csum_err) begin
            report_mismatch("checksum_error", 16'(got.csum_err), 16'(want.csum_err));
          end
          if (got.event_id !== want.event_id) begin
            report_mismatch("ack_event_id", 16'(got.event_id), 16'(want.event_id));
          end
          if (got.link !== want.link) begin
            report_mismatch("link_up", 16'(got.link), 16'(want.link));
          end
          if (got.call !== want.call) begin
            report_mismatch("call_state", 16'(got.call), 16'(want.call));
          end
          if (got.pad !== 1'b0) report_mismatch("padding bit", 16'(got.pad), 16'h0000);
        end
      end
      // Stall density drifts so that calm stretches alternate with busy ones.
      if ($urandom_range(0, 63) == 0) begin
        rcv_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 12);
      end
      if (hold_go) begin
        hold_go    = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && gaps_on && rcv_odds != 0 &&
                   $urandom_range(1, rcv_odds) == 1) begin
        stall_left = $urandom_range(1, 14);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run after too many cycles without any item moving.
  initial begin
    int idle_cyc;
    idle_cyc = 0;
    while (idle_cyc < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cyc = 0;
      end else begin
        idle_cyc++;
      end
    end
    $display("ERROR: no item moved for %0d cycles", WATCHDOG_LIMIT);
    $display("Some tests failed");
    $finish;
  end

endmodule
